FILE: rtl/rha_pkg.sv
// ----------------------------------------------------------------------------
// rha_pkg
// shared widths, defaults and codes of the reference counted handle allocator
// ----------------------------------------------------------------------------
`default_nettype none

package rha_pkg;

    localparam int HANDLE_W            = 10;
    localparam int OPCODE_W            = 2;
    localparam int STATUS_W            = 2;
    localparam int REFOUT_W            = 16;
    localparam int TABLE_ENTRIES_DEF   = 1024;
    localparam int COUNT_BITS_DEF      = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_ADDREF  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_CHECK   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD       = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/refcounted_handle_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_handle_allocator
// handle table with reference counts, free list reuse and bump allocation
//
// requests enter on in_valid/in_ready with opcode and handle: allocate,
// add reference, release or check. every request gives exactly one result
// on out_valid/out_ready with status, handle_out, entry_freed, ref_count.
// a request reads the count memory and the free link memory as it is
// accepted, then in its execute state modifies, writes back and loads
// the result register. a request is taken only in the idle state, as
// each does a single read-modify-write of the count memory.
// the result register parts the two channels: the next request is taken
// while a result still waits. if the receiver stalls, the following
// request waits in its execute cycle until the result register is free.
// reset empties the free list and the bump mark; the memories need no
// clearing pass, as entries at or above the bump mark are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_handle_allocator #(
    parameter int TABLE_ENTRIES = rha_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = rha_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [rha_pkg::OPCODE_W-1:0] opcode,
    input  wire logic [rha_pkg::HANDLE_W-1:0] handle,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [rha_pkg::STATUS_W-1:0] status,
    output logic      [rha_pkg::HANDLE_W-1:0] handle_out,
    output logic                              entry_freed,
    output logic      [rha_pkg::REFOUT_W-1:0] ref_count
);

    import rha_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic                  refs_we;
    logic [IDX_W-1:0]      refs_waddr;
    logic [COUNT_BITS-1:0] refs_wdata;
    logic                  refs_re;
    logic [IDX_W-1:0]      refs_raddr;
    logic [COUNT_BITS-1:0] refs_rdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [IDX_W:0]        link_wdata;
    logic                  link_re;
    logic [IDX_W-1:0]      link_raddr;
    logic [IDX_W:0]        link_rdata;

    // reference counts
    rha_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_refs_ram (
        .clk   (clk),
        .we    (refs_we),
        .waddr (refs_waddr),
        .wdata (refs_wdata),
        .re    (refs_re),
        .raddr (refs_raddr),
        .rdata (refs_rdata)
    );

    // free list links, valid bit on top
    rha_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (TABLE_ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    rha_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .handle      (handle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .handle_out  (handle_out),
        .entry_freed (entry_freed),
        .ref_count   (ref_count),
        .refs_we     (refs_we),
        .refs_waddr  (refs_waddr),
        .refs_wdata  (refs_wdata),
        .refs_re     (refs_re),
        .refs_raddr  (refs_raddr),
        .refs_rdata  (refs_rdata),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_re     (link_re),
        .link_raddr  (link_raddr),
        .link_rdata  (link_rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/rha_ram.sv
// ----------------------------------------------------------------------------
// rha_ram
// generic single write, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/rha_ctrl.sv
// ----------------------------------------------------------------------------
// rha_ctrl
// request sequencer: reads the entry and free link, modifies and writes back
// ----------------------------------------------------------------------------
`default_nettype none

module rha_ctrl #(
    parameter int TABLE_ENTRIES = rha_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = rha_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [rha_pkg::OPCODE_W-1:0]      opcode,
    input  wire logic [rha_pkg::HANDLE_W-1:0]      handle,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [rha_pkg::STATUS_W-1:0]      status,
    output logic      [rha_pkg::HANDLE_W-1:0]      handle_out,
    output logic                                   entry_freed,
    output logic      [rha_pkg::REFOUT_W-1:0]      ref_count,
    output logic                                   refs_we,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]  refs_waddr,
    output logic      [COUNT_BITS-1:0]             refs_wdata,
    output logic                                   refs_re,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]  refs_raddr,
    input  wire logic [COUNT_BITS-1:0]             refs_rdata,
    output logic                                   link_we,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]  link_waddr,
    output logic      [$clog2(TABLE_ENTRIES):0]    link_wdata,
    output logic                                   link_re,
    output logic      [$clog2(TABLE_ENTRIES)-1:0]  link_raddr,
    input  wire logic [$clog2(TABLE_ENTRIES):0]    link_rdata
);

    import rha_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int BW    = IDX_W + 1;
    localparam int CMP_W = (BW > HANDLE_W) ? BW : HANDLE_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    opcode_t               op_reg;
    logic [HANDLE_W-1:0]   h_reg;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic                  head_valid_reg, head_valid_next;
    logic [BW-1:0]         bump_reg, bump_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [HANDLE_W-1:0]   hout_reg, hout_next;
    logic                  freed_reg, freed_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic             accept;
    logic             commit;
    logic             in_range;
    logic [IDX_W-1:0] h_idx;
    logic [IDX_W-1:0] slot;

    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign h_idx    = IDX_W'(h_reg);
    assign in_range = CMP_W'(h_reg) < CMP_W'(bump_reg);

    assign in_ready   = (state_reg == S_IDLE);
    assign refs_re    = accept;
    assign refs_raddr = IDX_W'(handle);
    assign link_re    = accept;
    assign link_raddr = head_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        bump_next       = bump_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        hout_next       = hout_reg;
        freed_next      = freed_reg;
        cnt_next        = cnt_reg;
        slot            = head_reg;
        refs_we         = 1'b0;
        refs_waddr      = h_idx;
        refs_wdata      = refs_rdata;
        link_we         = 1'b0;
        link_waddr      = h_idx;
        link_wdata      = {head_valid_reg, head_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    hout_next      = h_reg;
                    freed_next     = 1'b0;
                    cnt_next       = '0;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (head_valid_reg)
                        begin
                            slot            = head_reg;
                            head_next       = link_rdata[IDX_W-1:0];
                            head_valid_next = link_rdata[IDX_W];
                        end
                        else
                        begin
                            slot = bump_reg[IDX_W-1:0];
                        end
                        if (head_valid_reg || (bump_reg < BW'(TABLE_ENTRIES)))
                        begin
                            if (!head_valid_reg)
                            begin
                                bump_next = bump_reg + BW'(1);
                            end
                            refs_we    = 1'b1;
                            refs_waddr = slot;
                            refs_wdata = COUNT_BITS'(1);
                            hout_next  = HANDLE_W'(slot);
                            cnt_next   = COUNT_BITS'(1);
                        end
                        else
                        begin
                            status_next = ST_FULL;
                            hout_next   = '0;
                        end
                    end
                    else if (!in_range || (refs_rdata == '0))
                    begin
                        status_next = ST_BAD;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_ADDREF:
                            begin
                                if (refs_rdata == '1)
                                begin
                                    status_next = ST_SATURATED;
                                    cnt_next    = refs_rdata;
                                end
                                else
                                begin
                                    cnt_next   = refs_rdata + COUNT_BITS'(1);
                                    refs_we    = 1'b1;
                                    refs_wdata = refs_rdata + COUNT_BITS'(1);
                                end
                            end
                            OP_RELEASE:
                            begin
                                cnt_next   = refs_rdata - COUNT_BITS'(1);
                                refs_we    = 1'b1;
                                refs_wdata = refs_rdata - COUNT_BITS'(1);
                                if (refs_rdata == COUNT_BITS'(1))
                                begin
                                    link_we         = 1'b1;
                                    head_next       = h_idx;
                                    head_valid_next = 1'b1;
                                    freed_next      = 1'b1;
                                end
                            end
                            default:
                            begin
                                cnt_next = refs_rdata;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            bump_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            bump_reg       <= bump_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= opcode_t'(opcode);
            h_reg  <= handle;
        end
        status_reg <= status_next;
        hout_reg   <= hout_next;
        freed_reg  <= freed_next;
        cnt_reg    <= cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign handle_out  = hout_reg;
    assign entry_freed = freed_reg;
    assign ref_count   = REFOUT_W'(cnt_reg);

endmodule

`default_nettype wire
